/* rtl/core/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types, operation codes and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WIDTH = 32;
   localparam int PW = 64;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ERROR    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_COMB,
      ST_GCD_START,
      ST_GCD_DIV,
      ST_GCD_STEP,
      ST_RED_NUM,
      ST_RED_NUM_WAIT,
      ST_RED_DEN,
      ST_RED_DEN_WAIT,
      ST_CHECK,
      ST_OUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic comb;
      logic div_start;
      logic div_sel_gcd;
      logic div_sel_num;
      logic gcd_step;
      logic store_num;
      logic store_den;
      logic check;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic err;
      logic num_zero;
      logic gcd_done;
      logic div_busy;
   } stat_type;

endpackage

/* rtl/core/rational_arithmetic_unit.sv */
// Error or zero results skip Euclid's loop and the two reducing divisions;
// other results pass through the products, one divider run per Euclid
// remainder step, then the two reducing divisions.
// Throughput: one request at a time; the 64-bit bit-serial divider sets it.
// Reset: synchronous, active high; returns the controller to idle.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // Fields from bit 0: a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95],
   // zero fill to 128 bits.
   input  logic [127:0]  req_tdata,
   // func, the operation code.
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // Fields from bit 0: res_num[31:0], res_den[62:32], zero fill to 64 bits.
   output logic [63:0]   rsp_tdata,
   // status.
   output logic [1:0]    rsp_tuser
);
   import rau_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [31:0] res_num;
   logic [30:0] res_den;

   // The controller steps through products, Euclid's loop, and the two divisions.
   rau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the operands and the shared divider.
   rau_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .func       (req_tuser),
      .a_num      (req_tdata[31:0]),
      .a_den      (req_tdata[62:32]),
      .b_num      (req_tdata[94:63]),
      .b_den      (req_tdata[125:95]),
      .res_num    (res_num),
      .res_den    (res_den),
      .res_status (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, res_den, res_num};
endmodule

/* rtl/core/rau_divider.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// ----------------------------------------------------------------------------
module rau_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rau_pkg::PW-1:0]    dividend,
   input  logic [rau_pkg::PW-1:0]    divisor,
   output logic                      busy,
   output logic [rau_pkg::PW-1:0]    quotient,
   output logic [rau_pkg::PW-1:0]    remainder
);
   import rau_pkg::*;

   logic [PW-1:0] quo_ff, quo_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] dsr_ff, dsr_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [PW:0]   trial;
   logic [PW:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[PW-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'(PW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[PW]) begin
            rem_in = diff[PW-1:0];
            quo_in = {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_in = trial[PW-1:0];
            quo_in = {quo_ff[PW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

/* rtl/core/rau_datapath.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, products, Euclid registers and the result check.
// ----------------------------------------------------------------------------
module rau_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  rau_pkg::cmd_type        cmd,
   output rau_pkg::stat_type       stat,
   input  logic [1:0]              func,
   input  logic [31:0]             a_num,
   input  logic [30:0]             a_den,
   input  logic [31:0]             b_num,
   input  logic [30:0]             b_den,
   output logic [31:0]             res_num,
   output logic [30:0]             res_den,
   output logic [1:0]              res_status
);
   import rau_pkg::*;

   logic [1:0]    op_ff;
   logic [31:0]   am_ff, bm_ff;
   logic [30:0]   ad_ff, bd_ff;
   logic          an_ff, bn_ff, err_ff;
   logic [PW-1:0] p_ff, q_ff, d_ff;
   logic [PW-1:0] nm_ff, dm_ff, nm_in;
   logic          neg_ff, neg_in;
   logic [PW-1:0] x_ff, y_ff;
   logic [31:0]   onum_ff;
   logic [30:0]   oden_ff;
   logic [1:0]    ost_ff;
   logic [31:0]   am_w, bm_w;
   logic          sb;
   logic          div_busy;
   logic [PW-1:0] div_q, div_r, div_a, div_b;
   logic [PW-1:0] lim;

   // The magnitude of the most negative numerator is 2^31, which still fits.
   assign am_w = a_num[31] ? (32'd0 - a_num) : a_num;
   assign bm_w = b_num[31] ? (32'd0 - b_num) : b_num;

   always_comb begin
      sb = (func_type'(op_ff) == FUNC_SUB) ? !bn_ff : bn_ff;
      neg_in = an_ff ^ bn_ff;
      nm_in  = p_ff;
      if (op_ff == FUNC_ADD || op_ff == FUNC_SUB) begin
         if (an_ff == sb) begin
            nm_in = p_ff + q_ff;
            neg_in = an_ff;
         end else if (p_ff >= q_ff) begin
            nm_in = p_ff - q_ff;
            neg_in = an_ff;
         end else begin
            nm_in = q_ff - p_ff;
            neg_in = sb;
         end
      end
   end

   always_comb begin
      if (cmd.div_sel_gcd) begin
         div_a = x_ff;
         div_b = y_ff;
      end else begin
         div_a = cmd.div_sel_num ? nm_ff : dm_ff;
         div_b = x_ff;
      end
   end

   rau_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign lim = PW'(1) << (WIDTH - 1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= func;
         an_ff  <= a_num[31];
         bn_ff  <= b_num[31];
         am_ff  <= am_w;
         bm_ff  <= bm_w;
         ad_ff  <= a_den;
         bd_ff  <= b_den;
         err_ff <= (a_den == '0) || (b_den == '0) ||
                   (func_type'(func) == FUNC_DIV && b_num == '0);
      end
      if (cmd.mul) begin
         case (func_type'(op_ff))
            FUNC_MUL: begin
               p_ff <= PW'(am_ff) * PW'(bm_ff);
               d_ff <= PW'(ad_ff) * PW'(bd_ff);
            end
            FUNC_DIV: begin
               p_ff <= PW'(am_ff) * PW'(bd_ff);
               d_ff <= PW'(ad_ff) * PW'(bm_ff);
            end
            default: begin
               p_ff <= PW'(am_ff) * PW'(bd_ff);
               q_ff <= PW'(bm_ff) * PW'(ad_ff);
               d_ff <= PW'(ad_ff) * PW'(bd_ff);
            end
         endcase
      end
      if (cmd.comb) begin
         nm_ff  <= nm_in;
         dm_ff  <= d_ff;
         neg_ff <= neg_in;
         x_ff   <= nm_in;
         y_ff   <= d_ff;
      end
      if (cmd.gcd_step) begin
         x_ff <= y_ff;
         y_ff <= div_r;
      end
      if (cmd.store_num) begin
         nm_ff <= div_q;
      end
      if (cmd.store_den) begin
         dm_ff <= div_q;
      end
      if (cmd.check) begin
         if (err_ff) begin
            onum_ff <= '0;
            oden_ff <= '0;
            ost_ff  <= STATUS_ERROR;
         end else if (nm_ff == '0) begin
            onum_ff <= '0;
            oden_ff <= 31'd1;
            ost_ff  <= STATUS_OK;
         end else if (dm_ff > lim - PW'(1) ||
                      (neg_ff ? (nm_ff > lim) : (nm_ff > lim - PW'(1)))) begin
            onum_ff <= '0;
            oden_ff <= '0;
            ost_ff  <= STATUS_OVERFLOW;
         end else begin
            onum_ff <= neg_ff ? (32'd0 - nm_ff[31:0]) : nm_ff[31:0];
            oden_ff <= dm_ff[30:0];
            ost_ff  <= STATUS_OK;
         end
      end
   end

   assign stat.err      = err_ff;
   assign stat.num_zero = (nm_ff == '0);
   assign stat.gcd_done = (y_ff == '0);
   assign stat.div_busy = div_busy;
   assign res_num    = onum_ff;
   assign res_den    = oden_ff;
   assign res_status = ost_ff;
endmodule

/* rtl/core/rau_controller.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences products, Euclid loop, reduction divisions and the output.
// ----------------------------------------------------------------------------
module rau_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output rau_pkg::cmd_type    cmd,
   input  rau_pkg::stat_type   stat
);
   import rau_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            cmd.comb = 1'b1;
            state_in = ST_GCD_START;
         end
         ST_GCD_START: begin
            if (stat.err || stat.num_zero) begin
               state_in = ST_CHECK;
            end else if (stat.gcd_done) begin
               state_in = ST_RED_NUM;
            end else begin
               cmd.div_sel_gcd = 1'b1;
               cmd.div_start   = 1'b1;
               state_in        = ST_GCD_DIV;
            end
         end
         ST_GCD_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_GCD_STEP;
            end
         end
         ST_GCD_STEP: begin
            cmd.gcd_step = 1'b1;
            state_in     = ST_GCD_START;
         end
         ST_RED_NUM: begin
            cmd.div_sel_num = 1'b1;
            cmd.div_start   = 1'b1;
            state_in        = ST_RED_NUM_WAIT;
         end
         ST_RED_NUM_WAIT: begin
            if (!stat.div_busy) begin
               cmd.store_num = 1'b1;
               state_in      = ST_RED_DEN;
            end
         end
         ST_RED_DEN: begin
            cmd.div_start = 1'b1;
            state_in      = ST_RED_DEN_WAIT;
         end
         ST_RED_DEN_WAIT: begin
            if (!stat.div_busy) begin
               cmd.store_den = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
